### rtl/gf2_poly_gcd_assert.svh
// Assertion macros for the GF(2) polynomial gcd block.
// Depends on nothing; included by modules that assert.
`ifndef GF2_POLY_GCD_ASSERT_SVH
`define GF2_POLY_GCD_ASSERT_SVH
// Implication checked on every clock edge outside reset.
`define GPG_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("assertion failed");
// Next-cycle implication outside reset.
`define GPG_ASSERT_NXT(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("assertion failed");
`endif

### rtl/gpg_pkg.sv
// Shared types for the GF(2) polynomial gcd block.
// No dependencies.
`timescale 1ns / 1ps
package gpg_pkg;
	// Control broadcast from the sequencer to every cell.
	typedef struct packed {
		logic load;  // take the new operands
		logic step;  // apply one reduction step
		logic sub;   // XOR the aligned divisor into the remainder
		logic swap;  // exchange remainder and divisor roles
	} cell_ctl_t;
endpackage

### rtl/gpg_cell.sv
// One coefficient slice of the gcd datapath: holds a remainder and divisor bit.
// Depends on gpg_pkg.
`timescale 1ns / 1ps
module gpg_cell (
	input  logic             clk,
	input  gpg_pkg::cell_ctl_t ctl,
	input  logic             a_in,
	input  logic             b_in,
	input  logic             b_lo,   // divisor bit from the lower neighbor
	input  logic             b_hi,   // divisor bit from the upper neighbor
	input  logic             shl,    // divisor moves up one place
	input  logic             shr,    // divisor moves down one place
	output logic             a_bit,
	output logic             b_bit
);
	logic a_q, b_q;
	assign a_bit = a_q;
	assign b_bit = b_q;

	// Remainder/divisor update: load, XOR-reduce, swap or shift.
	always_ff @(posedge clk) begin
		if (ctl.load) begin
			a_q <= a_in;
			b_q <= b_in;
		end else if (ctl.step) begin
			if (ctl.swap) begin
				a_q <= b_q;
				b_q <= a_q;
			end else if (ctl.sub) begin
				a_q <= a_q ^ b_q;
			end else if (shl) begin
				b_q <= b_lo;
			end else if (shr) begin
				b_q <= b_hi;
			end
		end
	end
endmodule

### rtl/gf2_poly_gcd.sv
// Top level of the GF(2) polynomial gcd block: a chain of bit cells + sequencer.
// Depends on gpg_pkg, gpg_cell and gf2_poly_gcd_assert.svh.
//
// channel | signals                        | direction
// in      | in_valid in_ready poly_a poly_b | to block
// out     | out_valid out_ready gcd_poly   | from block
//
// One word at a time. After the load cycle each cycle does one step: shift the
// divisor up under the remainder's top bit, XOR it in, shift it back down by the
// same count, or exchange the pair once the remainder is below the divisor.
// arst_n clears the sequencer; the result holds while out_ready is low.
`timescale 1ns / 1ps
`include "gf2_poly_gcd_assert.svh"
module gf2_poly_gcd #(
	parameter int POLY_BITS = 64
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic [63:0] poly_a,
	input  logic [63:0] poly_b,
	output logic        out_valid,
	input  logic        out_ready,
	output logic [63:0] gcd_poly
);
	localparam int N   = POLY_BITS;
	localparam int SHW = $clog2(N);

	typedef enum logic [1:0] {ST_IDLE, ST_RUN, ST_OUT} state_t;
	state_t state_q;

	logic [N-1:0] a_w, b_w, a_ld, b_ld;
	logic [N-1:0] fa, fb;
	gpg_pkg::cell_ctl_t ctl;
	logic shl, shr;
	logic [63:0] res_q;
	logic [SHW-1:0] sh_q;   // how far the divisor sits above its own place

	assign fa = poly_a[N-1:0];
	assign fb = poly_b[N-1:0];

	// Leading-bit masks: bits at and below the top set bit.
	logic [N-1:0] a_top, b_top;
	always_comb begin
		a_top[N-1] = a_w[N-1];
		b_top[N-1] = b_w[N-1];
		for (int i = N-2; i >= 0; i--) begin
			a_top[i] = a_top[i+1] | a_w[i];
			b_top[i] = b_top[i+1] | b_w[i];
		end
	end

	// Degree compares from the prefix masks.
	logic b_zero, a_lt_b, aligned, b_below;
	assign b_zero  = (b_w == '0);
	assign a_lt_b  = (a_top != b_top) && ((a_top & ~b_top) == '0); // deg a < deg b
	assign aligned = (a_top == b_top);
	assign b_below = !aligned && !a_lt_b;                          // deg b < deg a

	// Sequencer decisions per step.
	always_comb begin
		ctl.load = (state_q == ST_IDLE) && in_valid;
		ctl.step = (state_q == ST_RUN) && !b_zero;
		ctl.swap = 1'b0;
		ctl.sub  = 1'b0;
		shl = 1'b0;
		shr = 1'b0;
		if (aligned)
			ctl.sub = 1'b1;
		else if (b_below)
			shl = 1'b1;
		else if (sh_q != '0)
			shr = 1'b1;
		else
			ctl.swap = 1'b1;
	end
	// The divisor comes back down by exactly the up-shift count, so the
	// exchange always sees it in its own place.

	assign a_ld = fa;
	assign b_ld = fb;

	genvar gi;
	generate
		for (gi = 0; gi < N; gi++) begin : g_cell
			logic lo, hi;
			if (gi == 0) begin : g_lo
				assign lo = 1'b0;
			end else begin : g_lom
				assign lo = b_w[gi-1];
			end
			if (gi == N-1) begin : g_hi
				assign hi = 1'b0;
			end else begin : g_him
				assign hi = b_w[gi+1];
			end
			gpg_cell u_cell (
				.clk  (clk),
				.ctl  (ctl),
				.a_in (a_ld[gi]),
				.b_in (b_ld[gi]),
				.b_lo (lo),
				.b_hi (hi),
				.shl  (shl),
				.shr  (shr),
				.a_bit(a_w[gi]),
				.b_bit(b_w[gi])
			);
		end
	endgenerate

	// Sequencer, shift count and result register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			sh_q    <= '0;
			res_q   <= '0;
		end else begin
			unique case (state_q)
				ST_IDLE: if (in_valid) begin
					state_q <= ST_RUN;
					sh_q    <= '0;
				end
				ST_RUN: begin
					if (b_zero) begin
						state_q <= ST_OUT;
						res_q   <= 64'(a_w);
					end else if (shl) begin
						sh_q <= sh_q + 1'b1;
					end else if (shr) begin
						sh_q <= sh_q - 1'b1;
					end
				end
				ST_OUT: if (out_ready) state_q <= ST_IDLE;
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	assign in_ready  = (state_q == ST_IDLE);
	assign out_valid = (state_q == ST_OUT);
	assign gcd_poly  = res_q;

	`GPG_ASSERT_IMP(a_run_nz, clk, arst_n, (state_q == ST_RUN) && ctl.swap, a_w != '0 || b_w != '0)
	`GPG_ASSERT_NXT(a_done_out, clk, arst_n, (state_q == ST_RUN) && b_zero, out_valid)
	`GPG_ASSERT_IMP(a_one_op, clk, arst_n, ctl.step, $onehot({ctl.sub, ctl.swap, shl, shr}))
	`GPG_ASSERT_IMP(a_swap_home, clk, arst_n, ctl.step && ctl.swap, sh_q == '0)
endmodule
